// File: rtl/llt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the log line tokenizer.
// No dependencies; imported by log_line_tokenizer.
package llt_pkg;

  localparam int DIVIDER_RUN   = 10;
  localparam int MAX_TOKEN_LEN = 4095;
  localparam int POSITION_BITS = 16;

  localparam int LEN_W    = 12;
  localparam int OFFSET_W = 16;
  localparam int KIND_W   = 3;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CHAR_END     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_STRING = 2'd2,
    MODE_EQUALS = 2'd3
  } scan_mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPACE   = 3'd0,
    KIND_NEWLINE = 3'd1,
    KIND_COLON   = 3'd2,
    KIND_DIVIDER = 3'd3,
    KIND_NUMBER  = 3'd4,
    KIND_STRING  = 3'd5,
    KIND_END     = 3'd6
  } token_kind_t;

  typedef struct packed {
    token_kind_t          kind;
    logic [OFFSET_W-1:0]  offset;
    logic [LEN_W-1:0]     length;
    logic                 last;
  } token_t;

endpackage

// File: rtl/log_line_tokenizer.sv
`timescale 1ns / 1ps
// Log line tokenizer: scans text bytes and emits space, newline, colon,
// divider, number, string and end tokens. Depends on llt_pkg.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ---------------------------------------
//  char      char_valid / char_stall   char_code
//  token     token_valid / token_stall token_kind, token_offset, token_length,
//                                      last_of_run
//
// One byte is taken in every cycle unless char_stall is high. Its tokens (none,
// one or two) are worked out in the same cycle from the scan state and written
// into a four-entry output queue, so a token can be taken in the cycle after its
// byte at the earliest; the queue's read port delivers one token per cycle while
// token_stall is low. char_stall is raised while the queue has no room for two
// more tokens. rst is synchronous and clears the scan state and the queue.
module log_line_tokenizer import llt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  logic [7:0]          char_code,
  output logic                token_valid,
  input  logic                token_stall,
  output logic [KIND_W-1:0]   token_kind,
  output logic [OFFSET_W-1:0] token_offset,
  output logic [LEN_W-1:0]    token_length,
  output logic                last_of_run
);

  // Scan state.
  scan_mode_t                 scan_mode, scan_mode_next;
  logic [LEN_W-1:0]           run_length, run_length_next;
  logic [POSITION_BITS-1:0]   token_start, token_start_next;
  logic [POSITION_BITS-1:0]   byte_position, byte_position_next;

  // Output queue.
  token_t                     fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]           wr_ptr, rd_ptr;
  logic [CNT_W-1:0]           count, count_next;

  logic                       accept, pop;
  logic [1:0]                 n_tok;
  token_t                     first_tok, second_tok;

  // Byte classes.
  logic is_end, is_space, is_newline, is_colon, is_equals, is_num, is_text;
  logic [LEN_W-1:0] grown;

  assign accept     = char_valid && !char_stall;
  assign pop        = token_valid && !token_stall;
  assign char_stall = count > CNT_W'(FIFO_DEPTH - 2);

  assign is_end     = char_code == CHAR_END;
  assign is_space   = char_code == CHAR_SPACE;
  assign is_newline = char_code == CHAR_NEWLINE;
  assign is_colon   = char_code == CHAR_COLON;
  assign is_equals  = char_code == CHAR_EQUALS;
  assign is_num     = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_text    = !is_end && !is_num && !is_space && !is_newline && !is_colon;

  // Length of the pending token after one more byte, held at the maximum.
  assign grown = (run_length < LEN_W'(MAX_TOKEN_LEN)) ? run_length + LEN_W'(1)
                                                      : run_length;

  always_comb begin
    logic        flush;      // the pending token ends at this byte
    token_kind_t flush_kind;
    logic        do_begin;   // the byte is then scanned as if nothing pended
    logic        own_vld;
    token_t      own_tok;
    token_t      pend_tok;

    flush            = 1'b0;
    flush_kind       = KIND_STRING;
    do_begin         = 1'b0;
    own_vld          = 1'b0;
    own_tok.kind     = KIND_END;
    own_tok.offset   = byte_position[OFFSET_W-1:0];
    own_tok.length   = '0;
    own_tok.last     = 1'b1;
    scan_mode_next   = scan_mode;
    run_length_next  = run_length;
    token_start_next = token_start;

    unique case (scan_mode)
      MODE_NUMBER: begin
        if (is_num) begin
          run_length_next = grown;
        end else begin
          flush      = 1'b1;
          flush_kind = KIND_NUMBER;
          do_begin   = 1'b1;
        end
      end
      MODE_EQUALS: begin
        if (is_equals) begin
          run_length_next = grown;
          // Exactly the divider length of '=' bytes closes a divider at once.
          if (grown == LEN_W'(DIVIDER_RUN)) begin
            own_vld         = 1'b1;
            own_tok.kind    = KIND_DIVIDER;
            own_tok.offset  = token_start[OFFSET_W-1:0];
            own_tok.length  = grown;
            scan_mode_next  = MODE_IDLE;
            run_length_next = '0;
          end
        end else if (is_text) begin
          scan_mode_next  = MODE_STRING;
          run_length_next = grown;
        end else begin
          flush      = 1'b1;
          flush_kind = KIND_STRING;
          do_begin   = 1'b1;
        end
      end
      MODE_STRING: begin
        if (is_text) begin
          run_length_next = grown;
        end else begin
          flush      = 1'b1;
          flush_kind = KIND_STRING;
          do_begin   = 1'b1;
        end
      end
      MODE_IDLE: begin
        do_begin = 1'b1;
      end
      default: begin
        do_begin = 1'b1;
      end
    endcase

    if (do_begin) begin
      scan_mode_next  = MODE_IDLE;
      run_length_next = '0;
      if (is_end) begin
        own_vld      = 1'b1;
        own_tok.kind = KIND_END;
      end else if (is_space || is_newline || is_colon) begin
        own_vld        = 1'b1;
        own_tok.length = LEN_W'(1);
        if (is_space)        own_tok.kind = KIND_SPACE;
        else if (is_newline) own_tok.kind = KIND_NEWLINE;
        else                 own_tok.kind = KIND_COLON;
      end else begin
        token_start_next = byte_position;
        run_length_next  = LEN_W'(1);
        if (is_num) begin
          scan_mode_next = MODE_NUMBER;
        end else if (is_equals) begin
          scan_mode_next = MODE_EQUALS;
          if (DIVIDER_RUN == 1) begin
            own_vld         = 1'b1;
            own_tok.kind    = KIND_DIVIDER;
            own_tok.length  = LEN_W'(1);
            scan_mode_next  = MODE_IDLE;
            run_length_next = '0;
          end
        end else begin
          scan_mode_next = MODE_STRING;
        end
      end
    end

    pend_tok.kind   = flush_kind;
    pend_tok.offset = token_start[OFFSET_W-1:0];
    pend_tok.length = run_length;
    pend_tok.last   = !own_vld;

    first_tok  = flush ? pend_tok : own_tok;
    second_tok = own_tok;
    n_tok      = {1'b0, flush} + {1'b0, own_vld};

    // A zero byte restarts the position count for the next text.
    byte_position_next = is_end ? '0 : byte_position + POSITION_BITS'(1);
  end

  always_comb begin
    count_next = count;
    if (accept) count_next = count_next + CNT_W'(n_tok);
    if (pop)    count_next = count_next - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      run_length    <= '0;
      token_start   <= '0;
      byte_position <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (accept) begin
        scan_mode     <= scan_mode_next;
        run_length    <= run_length_next;
        token_start   <= token_start_next;
        byte_position <= byte_position_next;
        wr_ptr        <= wr_ptr + PTR_W'(n_tok);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Queue payload carries no reset.
  always_ff @(posedge clk) begin
    if (accept && (n_tok != 2'd0)) begin
      fifo_mem[wr_ptr] <= first_tok;
    end
    if (accept && (n_tok == 2'd2)) begin
      fifo_mem[wr_ptr + PTR_W'(1)] <= second_tok;
    end
  end

  assign token_valid  = count != '0;
  assign token_kind   = fifo_mem[rd_ptr].kind;
  assign token_offset = fifo_mem[rd_ptr].offset;
  assign token_length = fifo_mem[rd_ptr].length;
  assign last_of_run  = fifo_mem[rd_ptr].last;

endmodule

// File: tb/sv/log_line_tokenizer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for log_line_tokenizer: it feeds text bytes, predicts the
// token stream with a scanner of its own and checks every token item taken from the block.
// Depends on llt_pkg and rtl/log_line_tokenizer.sv; needs no files or arguments.
module log_line_tokenizer_tb import llt_pkg::*; ();

  localparam int RANDOM_BYTES = 1000;  // bytes in the random log-line part
  localparam int CALM_FROM    = 300;   // random bytes between these two run without idling
  localparam int CALM_TO      = 550;
  localparam int HOLD_CYCLES  = 300;   // receiver hold-off, long enough to fill the queue
  localparam int SETTLE       = 8;     // cycles allowed after the last token is expected
  localparam int MAX_REPORTS  = 200;

  // One row of the directed table. Where typed is set, the tokens in the row are the
  // expected ones; otherwise the scanner below works them out.
  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } stim_row_t;

  localparam token_t NO_TOKEN = '0;
  localparam int     DIRECTED_ROWS = 25;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                char_valid = 1'b0;
  logic                char_stall;
  logic [7:0]          char_code = CHAR_END;
  logic                token_valid;
  logic                token_stall = 1'b0;
  logic [KIND_W-1:0]   token_kind;
  logic [OFFSET_W-1:0] token_offset;
  logic [LEN_W-1:0]    token_length;
  logic                last_of_run;

  always #1 clk = ~clk;

  log_line_tokenizer u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_kind   (token_kind),
    .token_offset (token_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  // The directed part opens on a fresh text at position 0. It covers the three one-byte
  // tokens straight after reset, a number ended by a string byte, a string holding a byte
  // with the top bit set and an '=', a string ended by a colon, an exact divider, an
  // '=' run that turns into a string and is flushed by the end byte, and a second text
  // after the end, whose number is flushed by a further end byte.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CHAR_SPACE,   1'b1, 2'd1, '{KIND_SPACE,   16'd0,  12'd1,  1'b1}, NO_TOKEN},
    '{CHAR_NEWLINE, 1'b1, 2'd1, '{KIND_NEWLINE, 16'd1,  12'd1,  1'b1}, NO_TOKEN},
    '{CHAR_COLON,   1'b1, 2'd1, '{KIND_COLON,   16'd2,  12'd1,  1'b1}, NO_TOKEN},
    '{CHAR_ZERO,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_NINE,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'h61,        1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'hFF,        1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_COLON,   1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_EQUALS,  1'b1, 2'd1, '{KIND_DIVIDER, 16'd9,  12'd10, 1'b1}, NO_TOKEN},
    '{CHAR_EQUALS,  1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'h7F,        1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_END,     1'b1, 2'd2, '{KIND_STRING,  16'd19, 12'd2,  1'b0},
                                '{KIND_END,     16'd21, 12'd0,  1'b1}},
    '{8'h01,        1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_NINE,    1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CHAR_END,     1'b0, 2'd0, NO_TOKEN, NO_TOKEN}
  };

  // Scanner state, kept apart from the block's own.
  scan_mode_t               mode_s  = MODE_IDLE;
  logic [LEN_W-1:0]         run_s   = '0;
  logic [POSITION_BITS-1:0] start_s = '0;
  logic [POSITION_BITS-1:0] pos_s   = '0;

  token_t byte_tokens[$];      // tokens caused by the byte just scanned
  token_t expected_tokens[$];  // tokens still to come out of the block, oldest first

  int faults = 0;
  int sent   = 0;
  bit calm      = 1'b0;  // both sides stop idling while this is set
  bit want_hold = 1'b0;  // asks the receiver for one long hold-off
  int hold_left = 0;

  // Handshake outcomes and the token payload are sampled at the falling edge, half a
  // period before the rising edge that acts on them, so nothing hangs on the order in
  // which processes wake at the rising edge.
  bit     char_take  = 1'b0;
  bit     token_take = 1'b0;
  token_t token_seen;

  always @(negedge clk) begin
    char_take         = !rst && char_valid && !char_stall;
    token_take        = !rst && token_valid && !token_stall;
    token_seen.kind   = token_kind_t'(token_kind);
    token_seen.offset = token_offset;
    token_seen.length = token_length;
    token_seen.last   = last_of_run;
  end

  function automatic bit is_numeral(input logic [7:0] b);
    return b >= CHAR_ZERO && b <= CHAR_NINE;
  endfunction

  // A byte that can sit inside a string: anything but the end byte, a digit, or one of
  // the three one-byte tokens. The '=' byte counts as string text.
  function automatic bit is_word(input logic [7:0] b);
    return b != CHAR_END && !is_numeral(b) && b != CHAR_SPACE && b != CHAR_NEWLINE &&
           b != CHAR_COLON;
  endfunction

  function automatic void add_token(input token_kind_t kind,
                                    input logic [POSITION_BITS-1:0] at,
                                    input logic [LEN_W-1:0] len);
    token_t t;
    t.kind   = kind;
    t.offset = at[OFFSET_W-1:0];
    t.length = len;
    t.last   = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void grow_run();
    if (run_s < MAX_TOKEN_LEN) run_s = run_s + 1'b1;
  endfunction

  function automatic void open_run(input scan_mode_t mode, input logic [POSITION_BITS-1:0] at);
    mode_s  = mode;
    start_s = at;
    run_s   = LEN_W'(1);
  endfunction

  // Handles a byte when no token is pending: one-byte tokens come out at once, anything
  // else opens a run.
  function automatic void scan_fresh(input logic [7:0] b, input logic [POSITION_BITS-1:0] at);
    mode_s = MODE_IDLE;
    run_s  = '0;
    if (b == CHAR_END) begin
      add_token(KIND_END, at, LEN_W'(0));
    end else if (b == CHAR_SPACE) begin
      add_token(KIND_SPACE, at, LEN_W'(1));
    end else if (b == CHAR_NEWLINE) begin
      add_token(KIND_NEWLINE, at, LEN_W'(1));
    end else if (b == CHAR_COLON) begin
      add_token(KIND_COLON, at, LEN_W'(1));
    end else if (b == CHAR_EQUALS) begin
      open_run(MODE_EQUALS, at);
      if (run_s == DIVIDER_RUN) begin
        add_token(KIND_DIVIDER, start_s, run_s);
        mode_s = MODE_IDLE;
        run_s  = '0;
      end
    end else if (is_numeral(b)) begin
      open_run(MODE_NUMBER, at);
    end else begin
      open_run(MODE_STRING, at);
    end
  endfunction

  // Works out the tokens that one accepted byte causes and moves the scanner on.
  function automatic void tokenize_byte(input logic [7:0] b);
    logic [POSITION_BITS-1:0] at;
    at = pos_s;
    byte_tokens.delete();
    case (mode_s)
      MODE_NUMBER: begin
        if (is_numeral(b)) begin
          grow_run();
        end else begin
          add_token(KIND_NUMBER, start_s, run_s);
          scan_fresh(b, at);
        end
      end
      MODE_EQUALS: begin
        if (b == CHAR_EQUALS) begin
          grow_run();
          if (run_s == DIVIDER_RUN) begin
            add_token(KIND_DIVIDER, start_s, run_s);
            mode_s = MODE_IDLE;
            run_s  = '0;
          end
        end else if (is_word(b)) begin
          // A short '=' run followed by other text is simply the start of a string.
          mode_s = MODE_STRING;
          grow_run();
        end else begin
          add_token(KIND_STRING, start_s, run_s);
          scan_fresh(b, at);
        end
      end
      MODE_STRING: begin
        if (is_word(b)) begin
          grow_run();
        end else begin
          add_token(KIND_STRING, start_s, run_s);
          scan_fresh(b, at);
        end
      end
      default: begin
        scan_fresh(b, at);
      end
    endcase
    // The end byte restarts positions for the next text; otherwise they simply wrap.
    pos_s = (b == CHAR_END) ? '0 : at + 1'b1;
    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
  endfunction

  function automatic void report_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
    faults++;
    if (faults <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  // Compares a token item taken from the block with the oldest expectation.
  function automatic void check_token(input token_t got);
    token_t want;
    if (expected_tokens.size() == 0) begin
      faults++;
      if (faults <= MAX_REPORTS)
        $display("%0t: unexpected token, expected none, got kind %0d offset %0d length %0d",
                 $time, got.kind, got.offset, got.length);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind !== want.kind)
      report_field("token_kind", 16'(want.kind), 16'(got.kind));
    if (got.offset !== want.offset)
      report_field("token_offset", want.offset, got.offset);
    if (got.length !== want.length)
      report_field("token_length", 16'(want.length), 16'(got.length));
    if (got.last !== want.last)
      report_field("last_of_run", 16'(want.last), 16'(got.last));
  endfunction

  always @(posedge clk) begin
    if (token_take) check_token(token_seen);
  end

  // Receiver: stalls at random with a probability of six percent, not at all while calm is set, and once
  // holds off for a long stretch so that the output queue fills and the byte input stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        token_stall <= 1'b1;
      end else begin
        token_stall <= !calm && ($urandom_range(0, 99) < 6);
      end
    end
  end

  // Offers one byte and waits for the item to be accepted. The valid stays high after
  // acceptance so that back-to-back items need no dead cycle; whoever stops sending lowers it.
  task automatic offer(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 6) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= b;
    do @(posedge clk); while (!char_take);
  endtask

  task automatic send(input logic [7:0] b);
    offer(b);
    tokenize_byte(b);
    foreach (byte_tokens[j]) expected_tokens.push_back(byte_tokens[j]);
    sent++;
  endtask

  // Stops sending and waits until every expected token has come out.
  task automatic drain();
    char_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (!is_word(b));
    return b;
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
  endfunction

  // Sends one piece of a plausible log line: a word, a number, an '=' run around the
  // divider length, a separator, an end of text, or now and then a wholly random byte.
  task automatic send_piece();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      len = $urandom_range(1, 10);
      repeat (len) send(word_byte());
    end else if (pick < 50) begin
      len = $urandom_range(1, 8);
      repeat (len) send(digit_byte());
    end else if (pick < 62) begin
      case ($urandom_range(0, 3))
        0:       len = DIVIDER_RUN - 1;
        1:       len = DIVIDER_RUN;
        2:       len = DIVIDER_RUN + 1;
        default: len = $urandom_range(1, 2 * DIVIDER_RUN + 2);
      endcase
      repeat (len) send(CHAR_EQUALS);
      if ($urandom_range(0, 1) == 1) send(word_byte());
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0:       send(CHAR_SPACE);
        1:       send(CHAR_NEWLINE);
        default: send(CHAR_COLON);
      endcase
    end else if (pick < 92) begin
      send(CHAR_END);
    end else begin
      send(8'($urandom_range(0, 255)));
    end
  endtask

  // Sender: reset, the directed table, then random log lines.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer(directed_rows[i].code);
      tokenize_byte(directed_rows[i].code);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].count > 0) expected_tokens.push_back(directed_rows[i].first);
        if (directed_rows[i].count > 1) expected_tokens.push_back(directed_rows[i].second);
      end else begin
        foreach (byte_tokens[j]) expected_tokens.push_back(byte_tokens[j]);
      end
    end
    drain();

    // Random log lines. The receiver holds off early on while bytes keep coming, and a
    // stretch in the middle runs with no idling on either side.
    want_hold = 1'b1;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      calm = sent >= CALM_FROM && sent < CALM_TO;
      send_piece();
    end
    calm = 1'b0;
    send(CHAR_END);
    drain();

    if (faults == 0) begin
      $display("log_line_tokenizer_tb passed");
    end else begin
      $display("log_line_tokenizer_tb failed");
    end
    $finish;
  end

  // The slowest correct run takes well under a tenth of this.
  initial begin
    #2000000;
    $display("log_line_tokenizer_tb failed");
    $finish;
  end

endmodule
